@@ hw/rtl/ohlcv_pkg.sv @@
// shared constants, field layout and control types of the ohlcv bar aggregator
`timescale 1ns / 1ps

package ohlcv_pkg;

    // field widths
    localparam int SYM_W      = 32;
    localparam int KIND_W     = 3;
    localparam int SEC_W      = 17;
    localparam int PRICE_W    = 32;
    localparam int SIZE_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int ORDER_W    = 17;
    localparam int VOL_W      = 48;
    localparam int TRADES_W   = 32;

    // input item layout in s_tdata, lowest field first
    localparam int IN_SYM_LSB   = 0;
    localparam int IN_SEC_LSB   = IN_SYM_LSB + SYM_W;
    localparam int IN_PRICE_LSB = IN_SEC_LSB + SEC_W;
    localparam int IN_SIZE_LSB  = IN_PRICE_LSB + PRICE_W;
    localparam int IN_USED_W    = IN_SIZE_LSB + SIZE_W;
    localparam int S_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;
    localparam int S_TUSER_W    = KIND_W;

    // result item layout in m_tdata, lowest field first
    localparam int OUT_ORDER_LSB  = 0;
    localparam int OUT_OPEN_LSB   = OUT_ORDER_LSB + ORDER_W;
    localparam int OUT_HIGH_LSB   = OUT_OPEN_LSB + PRICE_W;
    localparam int OUT_LOW_LSB    = OUT_HIGH_LSB + PRICE_W;
    localparam int OUT_CLOSE_LSB  = OUT_LOW_LSB + PRICE_W;
    localparam int OUT_VOL_LSB    = OUT_CLOSE_LSB + PRICE_W;
    localparam int OUT_TRADES_LSB = OUT_VOL_LSB + VOL_W;
    localparam int OUT_USED_W     = OUT_TRADES_LSB + TRADES_W;
    localparam int M_TDATA_W      = ((OUT_USED_W + 7) / 8) * 8;
    localparam int M_TUSER_W      = STATUS_W + 1;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FILTER   = 1'd1;
    localparam logic [SEC_W-1:0]      INTERVAL_RESET = 17'd60;

    // tick kinds
    localparam logic [KIND_W-1:0] KIND_TRADE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL  = 3'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SYM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_KIND = 2'd2;

    // divider: one quotient bit per cycle
    localparam int DIV_STEPS = SEC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // controller to datapath commands
    typedef struct packed {
        logic load_in;   // capture the accepted item
        logic check;     // symbol and kind check, divider setup
        logic div_step;  // one division step
        logic update;    // open or merge the bar
        logic emit;      // move the result into the output register
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic reject;    // item fails the symbol or kind check
    } sts_t;

endpackage

@@ hw/rtl/ohlcv_ctrl.sv @@
// controller state machine of the ohlcv bar aggregator
`timescale 1ns / 1ps

module ohlcv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ohlcv_pkg::sts_t   sts,
    output ohlcv_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    localparam logic [ohlcv_pkg::DIV_CNT_W-1:0] CNT_LAST =
        ohlcv_pkg::DIV_CNT_W'(ohlcv_pkg::DIV_STEPS - 1);

    logic [2:0]                      state_reg, state_next;
    logic [ohlcv_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                            m_tvalid_reg, m_tvalid_next;

    // one item at a time, taken only when idle
    assign s_tready = (state_reg == S_IDLE) && aresetn;
    assign m_tvalid = m_tvalid_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                cnt_next   = '0;
                state_next = sts.reject ? S_EMIT : S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid: set on emit, cleared when the item is taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

@@ hw/rtl/ohlcv_dpath.sv @@
// datapath of the ohlcv bar aggregator: check, divider, bar state, output register
`timescale 1ns / 1ps

module ohlcv_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ohlcv_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ohlcv_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [ohlcv_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [ohlcv_pkg::S_TUSER_W-1:0]     s_tuser,
    input  ohlcv_pkg::cmd_t                     cmd,
    output ohlcv_pkg::sts_t                     sts,
    output logic [ohlcv_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [ohlcv_pkg::M_TUSER_W-1:0]     m_tuser
);

    // configuration registers
    logic [ohlcv_pkg::SEC_W-1:0]    interval_reg;
    logic [ohlcv_pkg::SYM_W-1:0]    filter_reg;

    // captured item
    logic [ohlcv_pkg::SYM_W-1:0]    sym_reg;
    logic [ohlcv_pkg::KIND_W-1:0]   kind_reg;
    logic [ohlcv_pkg::PRICE_W-1:0]  price_reg;
    logic [ohlcv_pkg::SIZE_W-1:0]   size_reg;

    // bar state
    logic [ohlcv_pkg::SYM_W-1:0]    bound_reg, bound_next;
    logic                           open_reg;
    logic [ohlcv_pkg::ORDER_W-1:0]  order_reg;
    logic [ohlcv_pkg::PRICE_W-1:0]  bopen_reg, high_reg, low_reg, close_reg;
    logic [ohlcv_pkg::VOL_W-1:0]    vol_reg;
    logic [ohlcv_pkg::TRADES_W-1:0] trades_reg;

    // divider
    logic [ohlcv_pkg::SEC_W-1:0]    div_reg;
    logic [ohlcv_pkg::SEC_W-1:0]    rem_reg;
    logic [ohlcv_pkg::SEC_W-1:0]    quo_reg;
    logic [ohlcv_pkg::SEC_W:0]      rem_sh;
    logic [ohlcv_pkg::SEC_W:0]      rem_sub;
    logic                           rem_ge;

    // pending result
    logic [ohlcv_pkg::OUT_USED_W-1:0] res_data_reg, res_data_next;
    logic [ohlcv_pkg::M_TUSER_W-1:0]  res_user_reg;
    logic [ohlcv_pkg::STATUS_W-1:0]   chk_status;
    logic [ohlcv_pkg::SYM_W-1:0]      acc_sym;

    // output register
    logic [ohlcv_pkg::OUT_USED_W-1:0] out_data_reg;
    logic [ohlcv_pkg::M_TUSER_W-1:0]  out_user_reg;

    // merge arithmetic
    logic                              new_bar;
    logic [ohlcv_pkg::VOL_W:0]         vol_sum;
    logic [ohlcv_pkg::VOL_W-1:0]       vol_merged;
    logic [ohlcv_pkg::TRADES_W-1:0]    trades_merged;

    // symbol and kind check on the captured item
    always_comb begin
        bound_next = bound_reg;
        if (filter_reg != '0) begin
            acc_sym = filter_reg;
        end else begin
            if (bound_reg == '0) begin
                bound_next = sym_reg;
            end
            acc_sym = bound_next;
        end
        if (sym_reg != acc_sym) begin
            chk_status = ohlcv_pkg::ST_BAD_SYM;
        end else if (kind_reg != ohlcv_pkg::KIND_TRADE && kind_reg != ohlcv_pkg::KIND_FULL) begin
            chk_status = ohlcv_pkg::ST_BAD_KIND;
        end else begin
            chk_status = ohlcv_pkg::ST_OK;
        end
    end

    assign sts.reject = (chk_status != ohlcv_pkg::ST_OK);

    // restoring division step
    assign rem_sh  = {rem_reg, quo_reg[ohlcv_pkg::SEC_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, div_reg});
    assign rem_sub = rem_sh - {1'b0, div_reg};

    // bar merge
    assign new_bar = !open_reg || (quo_reg != order_reg);
    assign vol_sum = {1'b0, vol_reg} + (ohlcv_pkg::VOL_W + 1)'(size_reg);
    assign vol_merged = vol_sum[ohlcv_pkg::VOL_W] ? '1 : vol_sum[ohlcv_pkg::VOL_W-1:0];
    assign trades_merged = (trades_reg == '1) ? trades_reg : trades_reg + 1'b1;

    // finished bar packed as a result item
    always_comb begin
        res_data_next = '0;
        res_data_next[ohlcv_pkg::OUT_ORDER_LSB  +: ohlcv_pkg::ORDER_W]  = order_reg;
        res_data_next[ohlcv_pkg::OUT_OPEN_LSB   +: ohlcv_pkg::PRICE_W]  = bopen_reg;
        res_data_next[ohlcv_pkg::OUT_HIGH_LSB   +: ohlcv_pkg::PRICE_W]  = high_reg;
        res_data_next[ohlcv_pkg::OUT_LOW_LSB    +: ohlcv_pkg::PRICE_W]  = low_reg;
        res_data_next[ohlcv_pkg::OUT_CLOSE_LSB  +: ohlcv_pkg::PRICE_W]  = close_reg;
        res_data_next[ohlcv_pkg::OUT_VOL_LSB    +: ohlcv_pkg::VOL_W]    = vol_reg;
        res_data_next[ohlcv_pkg::OUT_TRADES_LSB +: ohlcv_pkg::TRADES_W] = trades_reg;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= ohlcv_pkg::INTERVAL_RESET;
            filter_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ohlcv_pkg::CFG_INTERVAL: interval_reg <= cfg_wdata[ohlcv_pkg::SEC_W-1:0];
                ohlcv_pkg::CFG_FILTER:   filter_reg   <= cfg_wdata[ohlcv_pkg::SYM_W-1:0];
                default: ;
            endcase
        end
    end

    // control state of the bar
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_reg <= '0;
            open_reg  <= 1'b0;
        end else begin
            if (cmd.check) begin
                bound_reg <= bound_next;
            end
            if (cmd.update) begin
                open_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        // item capture
        if (cmd.load_in) begin
            sym_reg   <= s_tdata[ohlcv_pkg::IN_SYM_LSB   +: ohlcv_pkg::SYM_W];
            kind_reg  <= s_tuser;
            price_reg <= s_tdata[ohlcv_pkg::IN_PRICE_LSB +: ohlcv_pkg::PRICE_W];
            size_reg  <= s_tdata[ohlcv_pkg::IN_SIZE_LSB  +: ohlcv_pkg::SIZE_W];
            quo_reg   <= s_tdata[ohlcv_pkg::IN_SEC_LSB   +: ohlcv_pkg::SEC_W];
        end
        // divider setup and the default (rejected or empty) result
        if (cmd.check) begin
            div_reg      <= (interval_reg == '0) ? ohlcv_pkg::SEC_W'(1) : interval_reg;
            rem_reg      <= '0;
            res_data_reg <= '0;
            res_user_reg <= {1'b0, chk_status};
        end
        // one quotient bit per cycle
        if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_sub[ohlcv_pkg::SEC_W-1:0] : rem_sh[ohlcv_pkg::SEC_W-1:0];
            quo_reg <= {quo_reg[ohlcv_pkg::SEC_W-2:0], rem_ge};
        end
        // open a new bar or merge into the current one
        if (cmd.update) begin
            if (new_bar) begin
                if (open_reg) begin
                    res_data_reg <= res_data_next;
                    res_user_reg <= {1'b1, ohlcv_pkg::ST_OK};
                end
                order_reg  <= quo_reg;
                bopen_reg  <= price_reg;
                high_reg   <= price_reg;
                low_reg    <= price_reg;
                close_reg  <= price_reg;
                vol_reg    <= ohlcv_pkg::VOL_W'(size_reg);
                trades_reg <= ohlcv_pkg::TRADES_W'(1);
            end else begin
                trades_reg <= trades_merged;
                vol_reg    <= vol_merged;
                if (price_reg > high_reg) begin
                    high_reg <= price_reg;
                end
                if (price_reg < low_reg) begin
                    low_reg <= price_reg;
                end
                close_reg <= price_reg;
            end
        end
        // output register
        if (cmd.emit) begin
            out_data_reg <= res_data_reg;
            out_user_reg <= res_user_reg;
        end
    end

    assign m_tdata = ohlcv_pkg::M_TDATA_W'(out_data_reg);
    assign m_tuser = out_user_reg;

endmodule

@@ hw/rtl/ohlcv_bar_aggregator.sv @@
// top level of the ohlcv bar aggregator
//
//  channel   direction  payload
//  s_        in         tdata: symbol_id, elapsed_seconds, price, trade_size; tuser: data_kind
//  m_        out        tdata: done_order..done_trades; tuser: status, bar_done
//  cfg_      in         write only: 0 interval_seconds, 1 symbol_filter
//
// an item passes from acceptance to a result in the output register through these steps:
// capture, check, 17 steps of the serial divider, bar update, load of the output.
// a rejected item skips the divider and the bar update.
// s_tready is low from acceptance until the result is loaded; a stalled m_ side
// holds the block in its final state until the previous result is taken.
// aresetn is synchronous; it clears the bar and the bound symbol, sets interval_seconds to 60 and symbol_filter to 0.
`timescale 1ns / 1ps

module ohlcv_bar_aggregator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [ohlcv_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ohlcv_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // tick input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // symbol_id, elapsed_seconds, price, trade_size, zero pad
    input  logic [ohlcv_pkg::S_TDATA_W-1:0]     s_tdata,
    // data_kind
    input  logic [ohlcv_pkg::S_TUSER_W-1:0]     s_tuser,
    // result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // done_order, done_open, done_high, done_low, done_close, done_volume,
    // done_trades, zero pad
    output logic [ohlcv_pkg::M_TDATA_W-1:0]     m_tdata,
    // status, bar_done
    output logic [ohlcv_pkg::M_TUSER_W-1:0]     m_tuser
);

    ohlcv_pkg::cmd_t cmd;
    ohlcv_pkg::sts_t sts;

    // sequencing
    ohlcv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic and bar state
    ohlcv_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ hw/rtl/ohlcv_chk.sv @@
// port-level checks of the ohlcv bar aggregator and their binding
`timescale 1ns / 1ps

module ohlcv_chk (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [ohlcv_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [ohlcv_pkg::M_TUSER_W-1:0]     m_tuser
);

    // a result waiting on a stalled output stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one item in flight: no second item right after an accepted one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("item accepted while the previous one is in work");

    // a rejected item carries no bar
    a_reject_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] != ohlcv_pkg::ST_OK) |-> !m_tuser[2] && (m_tdata == '0))
        else $error("rejected item carries bar data");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1:0] == ohlcv_pkg::ST_OK) || (m_tuser[1:0] == ohlcv_pkg::ST_BAD_SYM)
                  || (m_tuser[1:0] == ohlcv_pkg::ST_BAD_KIND))
        else $error("undefined status code");

endmodule

bind ohlcv_bar_aggregator ohlcv_chk u_chk (.*);

@@ bench/tb_ohlcv_bar_aggregator.sv @@
// self-checking bench of the ohlcv bar aggregator: directed ticks, then random phases
`timescale 1ns / 1ps

module tb_ohlcv_bar_aggregator;

    // one tick as it enters on s_
    typedef struct {
        logic [ohlcv_pkg::SYM_W-1:0]   sym;
        logic [ohlcv_pkg::KIND_W-1:0]  kind;
        logic [ohlcv_pkg::SEC_W-1:0]   sec;
        logic [ohlcv_pkg::PRICE_W-1:0] price;
        logic [ohlcv_pkg::SIZE_W-1:0]  size;
    } tick_t;

    // one result as it leaves on m_
    typedef struct {
        logic [ohlcv_pkg::STATUS_W-1:0] status;
        logic                           bar_done;
        logic [ohlcv_pkg::ORDER_W-1:0]  order;
        logic [ohlcv_pkg::PRICE_W-1:0]  open;
        logic [ohlcv_pkg::PRICE_W-1:0]  high;
        logic [ohlcv_pkg::PRICE_W-1:0]  low;
        logic [ohlcv_pkg::PRICE_W-1:0]  close;
        logic [ohlcv_pkg::VOL_W-1:0]    volume;
        logic [ohlcv_pkg::TRADES_W-1:0] trades;
    } bar_result_t;

    // directed row: typed rows carry a plain status with no finished bar
    typedef struct {
        tick_t                          tk;
        bit                             typed;
        logic [ohlcv_pkg::STATUS_W-1:0] status;
    } dir_row_t;

    localparam int unsigned SEC_MAX = (1 << ohlcv_pkg::SEC_W) - 1;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [ohlcv_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [ohlcv_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [ohlcv_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [ohlcv_pkg::S_TUSER_W-1:0]  s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [ohlcv_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [ohlcv_pkg::M_TUSER_W-1:0]  m_tuser;

    // predicted aggregator state and registers
    logic [ohlcv_pkg::SEC_W-1:0]    ag_interval;
    logic [ohlcv_pkg::SYM_W-1:0]    ag_filter;
    logic [ohlcv_pkg::SYM_W-1:0]    ag_bound;
    logic                           ag_bar_open;
    logic [ohlcv_pkg::ORDER_W-1:0]  ag_order;
    logic [ohlcv_pkg::PRICE_W-1:0]  ag_open;
    logic [ohlcv_pkg::PRICE_W-1:0]  ag_high;
    logic [ohlcv_pkg::PRICE_W-1:0]  ag_low;
    logic [ohlcv_pkg::PRICE_W-1:0]  ag_close;
    logic [ohlcv_pkg::VOL_W-1:0]    ag_volume;
    logic [ohlcv_pkg::TRADES_W-1:0] ag_trades;

    bar_result_t expected_bars[$];
    dir_row_t    dir_rows[$];
    int unsigned mismatch_count = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    int unsigned sec_cursor = 0;
    logic [ohlcv_pkg::PRICE_W-1:0] last_price = 32'd100000;

    ohlcv_bar_aggregator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result with only a status, no finished bar
    function automatic bar_result_t plain_status(logic [ohlcv_pkg::STATUS_W-1:0] status);
        bar_result_t res;
        res = '{default: '0};
        res.status = status;
        return res;
    endfunction

    // predict the result of one tick and advance the bar state
    function automatic bar_result_t aggregate_tick(tick_t tk);
        bar_result_t                   res;
        logic [ohlcv_pkg::SYM_W-1:0]   want_sym;
        logic [ohlcv_pkg::SEC_W-1:0]   divisor;
        logic [ohlcv_pkg::ORDER_W-1:0] order;
        logic [ohlcv_pkg::VOL_W:0]     vsum;
        if (ag_filter != '0) begin
            want_sym = ag_filter;
        end else begin
            // adopt the first symbol seen, even on a tick rejected later
            if (ag_bound == '0)
                ag_bound = tk.sym;
            want_sym = ag_bound;
        end
        if (tk.sym != want_sym)
            return plain_status(ohlcv_pkg::ST_BAD_SYM);
        if (tk.kind != ohlcv_pkg::KIND_TRADE && tk.kind != ohlcv_pkg::KIND_FULL)
            return plain_status(ohlcv_pkg::ST_BAD_KIND);

        divisor = (ag_interval == '0) ? ohlcv_pkg::SEC_W'(1) : ag_interval;
        order   = ohlcv_pkg::ORDER_W'(tk.sec / divisor);
        res     = plain_status(ohlcv_pkg::ST_OK);
        if (!ag_bar_open || order != ag_order) begin
            // finish the open bar, if any, and start a new one
            if (ag_bar_open) begin
                res.bar_done = 1'b1;
                res.order    = ag_order;
                res.open     = ag_open;
                res.high     = ag_high;
                res.low      = ag_low;
                res.close    = ag_close;
                res.volume   = ag_volume;
                res.trades   = ag_trades;
            end
            ag_bar_open = 1'b1;
            ag_order    = order;
            ag_open     = tk.price;
            ag_high     = tk.price;
            ag_low      = tk.price;
            ag_close    = tk.price;
            ag_volume   = ohlcv_pkg::VOL_W'(tk.size);
            ag_trades   = ohlcv_pkg::TRADES_W'(1);
        end else begin
            // merge into the open bar, saturating counters
            if (ag_trades != '1)
                ag_trades = ag_trades + 1'b1;
            vsum = {1'b0, ag_volume} + (ohlcv_pkg::VOL_W+1)'(tk.size);
            ag_volume = vsum[ohlcv_pkg::VOL_W] ? '1 : vsum[ohlcv_pkg::VOL_W-1:0];
            if (tk.price > ag_high)
                ag_high = tk.price;
            if (tk.price < ag_low)
                ag_low = tk.price;
            ag_close = tk.price;
        end
        return res;
    endfunction

    // append one directed row to the table
    function automatic void add_row(logic [ohlcv_pkg::SYM_W-1:0] sym,
                                    logic [ohlcv_pkg::KIND_W-1:0] kind,
                                    logic [ohlcv_pkg::SEC_W-1:0] sec,
                                    logic [ohlcv_pkg::PRICE_W-1:0] price,
                                    logic [ohlcv_pkg::SIZE_W-1:0] size, bit typed,
                                    logic [ohlcv_pkg::STATUS_W-1:0] status);
        dir_row_t r;
        r.tk.sym   = sym;
        r.tk.kind  = kind;
        r.tk.sec   = sec;
        r.tk.price = price;
        r.tk.size  = size;
        r.typed    = typed;
        r.status   = status;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // random tick: mostly well-formed trades walking through the day
    function automatic tick_t next_tick();
        tick_t                       tk;
        int unsigned                 pick;
        int unsigned                 divisor;
        logic [ohlcv_pkg::SYM_W-1:0] good;
        good = (ag_filter != '0) ? ag_filter : ag_bound;
        if (good == '0)
            good = $urandom;
        pick = $urandom_range(0, 99);
        tk.sym = good;
        if (pick < 4)
            tk.sym = $urandom;
        else if (pick < 8)
            tk.sym = good ^ (32'd1 << $urandom_range(0, 31));
        if (pick >= 8 && pick < 15)
            tk.kind = ohlcv_pkg::KIND_W'($urandom_range(2, 7));
        else
            tk.kind = ohlcv_pkg::KIND_W'($urandom_range(0, 1));

        // elapsed time: small forward steps, with jumps and restarts
        divisor = (ag_interval == '0) ? 1 : int'(ag_interval);
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            sec_cursor = $urandom_range(0, SEC_MAX);
        end else if (pick == 1) begin
            sec_cursor = 0;
        end else begin
            sec_cursor += $urandom_range(0, divisor / 4 + 1);
            if (sec_cursor > SEC_MAX)
                sec_cursor = $urandom_range(0, 1000);
        end
        tk.sec = ohlcv_pkg::SEC_W'(sec_cursor);

        pick = $urandom_range(0, 15);
        if (pick == 0)
            last_price = '0;
        else if (pick == 1)
            last_price = '1;
        else if (pick < 4)
            last_price = $urandom;
        else
            last_price = last_price + ohlcv_pkg::PRICE_W'($urandom_range(0, 200))
                         - ohlcv_pkg::PRICE_W'(100);
        tk.price = last_price;

        pick = $urandom_range(0, 15);
        if (pick < 4)
            tk.size = $urandom;
        else if (pick == 4)
            tk.size = '1;
        else
            tk.size = ohlcv_pkg::SIZE_W'($urandom_range(0, 1000));
        return tk;
    endfunction

    // offer one tick after a random gap and queue its result on acceptance
    task automatic send_tick(input tick_t tk, input bit typed, input bar_result_t typed_res);
        int unsigned                     gap;
        logic [ohlcv_pkg::S_TDATA_W-1:0] word;
        bar_result_t                     res;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        word = '0;
        word[ohlcv_pkg::IN_SYM_LSB   +: ohlcv_pkg::SYM_W]   = tk.sym;
        word[ohlcv_pkg::IN_SEC_LSB   +: ohlcv_pkg::SEC_W]   = tk.sec;
        word[ohlcv_pkg::IN_PRICE_LSB +: ohlcv_pkg::PRICE_W] = tk.price;
        word[ohlcv_pkg::IN_SIZE_LSB  +: ohlcv_pkg::SIZE_W]  = tk.size;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= tk.kind;
        do @(posedge aclk); while (!s_tready);
        res = aggregate_tick(tk);
        expected_bars.insert(expected_bars.size(), typed ? typed_res : res);
        @(negedge aclk);
    endtask

    // hold the input off until every queued result has come out
    task automatic wait_bars_flushed();
        s_tvalid <= 1'b0;
        while (expected_bars.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // write both registers on consecutive cycles
    task automatic write_config(input logic [ohlcv_pkg::CFG_DATA_W-1:0] interval_word,
                                input logic [ohlcv_pkg::CFG_DATA_W-1:0] filter_word);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= ohlcv_pkg::CFG_INTERVAL;
        cfg_wdata   <= interval_word;
        ag_interval = interval_word[ohlcv_pkg::SEC_W-1:0];
        @(negedge aclk);
        cfg_addr    <= ohlcv_pkg::CFG_FILTER;
        cfg_wdata   <= filter_word;
        ag_filter   = filter_word[ohlcv_pkg::SYM_W-1:0];
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // result side: random stall before taking each item
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // compare every accepted result with the oldest prediction
    always @(posedge aclk) begin
        bar_result_t want;
        if (aresetn === 1'b1 && m_tvalid && m_tready) begin
            if (expected_bars.size() == 0) begin
                $error("result with no tick waiting: tuser %0h tdata %0h", m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = expected_bars.pop_front();
                check_field("status", want.status, m_tuser[ohlcv_pkg::STATUS_W-1:0]);
                check_field("bar_done", want.bar_done, m_tuser[ohlcv_pkg::STATUS_W]);
                check_field("done_order", want.order,
                            m_tdata[ohlcv_pkg::OUT_ORDER_LSB +: ohlcv_pkg::ORDER_W]);
                check_field("done_open", want.open,
                            m_tdata[ohlcv_pkg::OUT_OPEN_LSB +: ohlcv_pkg::PRICE_W]);
                check_field("done_high", want.high,
                            m_tdata[ohlcv_pkg::OUT_HIGH_LSB +: ohlcv_pkg::PRICE_W]);
                check_field("done_low", want.low,
                            m_tdata[ohlcv_pkg::OUT_LOW_LSB +: ohlcv_pkg::PRICE_W]);
                check_field("done_close", want.close,
                            m_tdata[ohlcv_pkg::OUT_CLOSE_LSB +: ohlcv_pkg::PRICE_W]);
                check_field("done_volume", want.volume,
                            m_tdata[ohlcv_pkg::OUT_VOL_LSB +: ohlcv_pkg::VOL_W]);
                check_field("done_trades", want.trades,
                            m_tdata[ohlcv_pkg::OUT_TRADES_LSB +: ohlcv_pkg::TRADES_W]);
            end
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // stimulus
    initial begin
        logic [ohlcv_pkg::CFG_DATA_W-1:0] iv;
        logic [ohlcv_pkg::CFG_DATA_W-1:0] fl;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = ohlcv_pkg::CFG_INTERVAL;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;

        // predictor state after reset
        ag_interval = ohlcv_pkg::INTERVAL_RESET;
        ag_filter   = '0;
        ag_bound    = '0;
        ag_bar_open = 1'b0;
        ag_order    = '0;
        ag_open     = '0;
        ag_high     = '0;
        ag_low      = '0;
        ag_close    = '0;
        ag_volume   = '0;
        ag_trades   = '0;

        // directed ticks, reset register values
        // symbol 0 is taken but leaves the block unbound; the first bar finishes nothing
        add_row(32'h0, ohlcv_pkg::KIND_TRADE, 17'd0, 32'h0, 32'h0, 1, ohlcv_pkg::ST_OK);
        // adoption happens even on a tick rejected for its kind
        add_row('1, 3'd7, 17'd0, 32'h0, 32'h0, 1, ohlcv_pkg::ST_BAD_KIND);
        add_row(32'h1, ohlcv_pkg::KIND_TRADE, 17'd0, 32'h0, 32'h0, 1, ohlcv_pkg::ST_BAD_SYM);
        add_row(32'h0, ohlcv_pkg::KIND_TRADE, 17'd0, 32'h0, 32'h0, 1, ohlcv_pkg::ST_BAD_SYM);
        add_row('1, ohlcv_pkg::KIND_FULL, 17'd59, '1, '1, 0, ohlcv_pkg::ST_OK);
        add_row('1, ohlcv_pkg::KIND_TRADE, 17'd30, 32'h0, 32'h0, 0, ohlcv_pkg::ST_OK);
        add_row('1, ohlcv_pkg::KIND_TRADE, 17'd60, 32'd12345, 32'd7, 0, ohlcv_pkg::ST_OK);
        add_row('1, 3'd2, 17'd60, 32'd1, 32'd1, 1, ohlcv_pkg::ST_BAD_KIND);
        add_row('1, 3'd3, 17'd60, 32'd1, 32'd1, 1, ohlcv_pkg::ST_BAD_KIND);
        add_row('1, 3'd4, 17'd60, 32'd1, 32'd1, 1, ohlcv_pkg::ST_BAD_KIND);
        add_row('1, 3'd5, 17'd60, 32'd1, 32'd1, 1, ohlcv_pkg::ST_BAD_KIND);
        add_row('1, 3'd6, 17'd60, 32'd1, 32'd1, 1, ohlcv_pkg::ST_BAD_KIND);
        // last second of the day, then elapsed beyond the day
        add_row('1, ohlcv_pkg::KIND_TRADE, 17'd86399, 32'd5000, '1, 0, ohlcv_pkg::ST_OK);
        add_row('1, ohlcv_pkg::KIND_FULL, 17'd86399, 32'd7000, 32'd3, 0, ohlcv_pkg::ST_OK);
        add_row('1, ohlcv_pkg::KIND_TRADE, '1, 32'd1, 32'd1, 0, ohlcv_pkg::ST_OK);
        add_row('1, ohlcv_pkg::KIND_TRADE, 17'd60, 32'd2, 32'd2, 0, ohlcv_pkg::ST_OK);
        add_row(32'hFFFF_FFFE, ohlcv_pkg::KIND_TRADE, 17'd61, 32'd1, 32'd1, 1,
                ohlcv_pkg::ST_BAD_SYM);
        add_row('1, ohlcv_pkg::KIND_FULL, 17'd61, 32'h8000_0000, 32'h0, 0, ohlcv_pkg::ST_OK);
        add_row('1, ohlcv_pkg::KIND_TRADE, 17'd65535, 32'hAAAA_AAAA, 32'h5555_5555, 0,
                ohlcv_pkg::ST_OK);
        add_row('1, ohlcv_pkg::KIND_TRADE, 17'd65536, 32'h5555_5555, 32'hAAAA_AAAA, 0,
                ohlcv_pkg::ST_OK);
        add_row('1, ohlcv_pkg::KIND_TRADE, 17'd0, 32'h0, 32'h0, 0, ohlcv_pkg::ST_OK);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i])
            send_tick(dir_rows[i].tk, dir_rows[i].typed, plain_status(dir_rows[i].status));

        // random phases, each under its own register setting
        for (int phase = 0; phase < 7; phase++) begin
            wait_bars_flushed();
            case (phase)
                0: begin iv = 32'd1;                   fl = '0;                end
                1: begin iv = 32'd86400;               fl = 32'h1234_5678;     end
                // zero interval, with junk above the register width
                2: begin iv = {15'($urandom), 17'd0};  fl = '1;                end
                3: begin iv = 32'(SEC_MAX);            fl = $urandom | 32'd1;  end
                4: begin iv = $urandom_range(2, 300);  fl = '0;                end
                5: begin iv = 32'(ohlcv_pkg::INTERVAL_RESET); fl = $urandom;   end
                default: begin
                    iv = {15'($urandom), 17'($urandom_range(1, 20))};
                    fl = '0;
                end
            endcase
            write_config(iv, fl);
            for (int n = 0; n < 200; n++) begin
                if ($urandom_range(0, 149) == 0)
                    wait_bars_flushed();
                send_tick(next_tick(), 1'b0, plain_status(ohlcv_pkg::ST_OK));
            end
        end

        // drain and let the block settle
        wait_bars_flushed();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ohlcv_pkg.sv
hw/rtl/ohlcv_ctrl.sv
hw/rtl/ohlcv_dpath.sv
hw/rtl/ohlcv_bar_aggregator.sv
hw/rtl/ohlcv_chk.sv
bench/tb_ohlcv_bar_aggregator.sv
